@@ rtl/scsa_pkg.sv @@
// scsa_pkg: shared types, codes and constants of the size class slab allocator
// no dependencies; imported by every module of the block but scsa_ram
package scsa_pkg;

	// fixed field widths
	localparam int ADDR_W    = 22;
	localparam int SIZE_W    = 16;
	localparam int STATUS_W  = 3;
	localparam int S_DATA_W  = 40;
	localparam int S_USER_W  = 1;
	localparam int M_DATA_W  = 32;

	// class index covers up to eight classes; per class tables have one slot per code
	localparam int CLS_W     = 3;
	localparam int CLS_SLOTS = 8;

	// object index fits below 2**21 for any pool and object size in range
	localparam int IDX_MAX_W = 21;
	// largest object size is 256 << 7
	localparam int OB_W      = 16;
	// reciprocal of an object size, scaled to stay exact for 22 bit offsets
	localparam int REC_W     = 24;

	// request kind carried in tuser
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_NOT_OWNED = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_FREE,
		OP_REJECT
	} op_kind_t;

	// classified request handed from the front to the back
	typedef struct packed {
		op_kind_t               kind;
		status_t                status;
		logic [CLS_W-1:0]       cls;
		logic [IDX_MAX_W-1:0]   idx;
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_MUL,
		BK_DONE
	} bk_state_t;

	// first stack slot of class c; class k holds count0 >> k objects
	function automatic int unsigned stack_base(int unsigned count0, int unsigned c);
		int unsigned acc;
		acc = 0;
		for (int unsigned k = 0; k < c; k++) begin
			acc += count0 >> k;
		end
		return acc;
	endfunction

	// stack slots over all classes
	function automatic int unsigned stack_total(int unsigned count0, int unsigned n);
		return stack_base(count0, n);
	endfunction

endpackage

@@ rtl/scsa_ram.sv @@
// scsa_ram: generic single write port, single read port ram with registered read
// no dependencies
module scsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/scsa_fifo.sv @@
// scsa_fifo: short queue of classified requests between front and back
// depends on scsa_pkg for op_t
module scsa_fifo
	import scsa_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  wdata,
	output logic full,
	input  logic pop,
	output op_t  rdata,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

endmodule

@@ rtl/scsa_front.sv @@
// scsa_front: three stage classifier; maps sizes to classes and checks freed addresses
// depends on scsa_pkg; feeds op_t requests into scsa_fifo
module scsa_front
	import scsa_pkg::*;
#(
	parameter int POOL_BYTES       = 1048576,
	parameter int MIN_OBJECT_BYTES = 32,
	parameter int NUM_CLASSES      = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_action,
	input  logic [SIZE_W-1:0] in_size,
	input  logic [ADDR_W-1:0] in_addr,
	output logic              op_push,
	output op_t               op,
	input  logic              q_full
);

	localparam int unsigned COUNT0 = POOL_BYTES / MIN_OBJECT_BYTES;
	localparam int CNT_W   = $clog2(COUNT0 + 1);
	// offset divided by an object of at least 8 bytes
	localparam int FQ_W    = ADDR_W - 3;
	localparam int PROD_W  = ADDR_W + REC_W;
	localparam int SH_W    = $clog2(PROD_W);
	localparam int CHK_W   = FQ_W + OB_W;
	localparam longint TOP_L  = longint'(CLS_SLOTS) * longint'(POOL_BYTES);
	localparam int RNG_RAW = $clog2(TOP_L + 1);
	localparam int RNG_W   = (RNG_RAW > ADDR_W) ? RNG_RAW : ADDR_W + 1;
	localparam logic [RNG_W-1:0] OWN_LIM =
		RNG_W'(longint'(NUM_CLASSES) * longint'(POOL_BYTES));

	// per class constant tables
	logic [OB_W-1:0]  ob_tab    [CLS_SLOTS];
	logic [REC_W-1:0] rec_tab   [CLS_SLOTS];
	logic [SH_W-1:0]  sh_tab    [CLS_SLOTS];
	logic [CNT_W-1:0] cnt_tab   [CLS_SLOTS];
	logic [RNG_W-1:0] pbase_tab [CLS_SLOTS];

	for (genvar g = 0; g < CLS_SLOTS; g++) begin : g_tab
		localparam longint OB  = longint'(MIN_OBJECT_BYTES) << g;
		localparam int     SH  = ADDR_W + $clog2(OB);
		localparam longint RC  = ((longint'(1) << SH) + OB - 1) / OB;
		localparam longint CNT = (g < NUM_CLASSES) ? (longint'(COUNT0) >> g) : 0;
		localparam longint PB  = longint'(g) * longint'(POOL_BYTES);
		assign ob_tab[g]    = OB_W'(OB);
		assign rec_tab[g]   = REC_W'(RC);
		assign sh_tab[g]    = SH_W'(SH);
		assign cnt_tab[g]   = CNT_W'(CNT);
		assign pbase_tab[g] = RNG_W'(PB);
	end

	logic                 adv;
	logic                 v_s1, v_s2, v_s3;
	logic                 act_s1, act_s2;
	logic [CLS_W-1:0]     cls_s1, cls_s2;
	logic [ADDR_W-1:0]    off_s1, off_s2;
	logic                 bad_s1, bad_s2;
	logic [FQ_W-1:0]      q_s2;
	op_t                  op_s3;

	logic [CLS_W-1:0]     cls_a, cls_f;
	logic                 fit, own;
	logic [RNG_W-1:0]     addr_x;
	logic [ADDR_W-1:0]    off_f;
	logic [PROD_W-1:0]    prod;
	logic [FQ_W-1:0]      q_d;
	logic [CHK_W-1:0]     chk;
	logic                 aligned, in_pool;
	op_t                  op_d;

	// the whole pipeline moves unless its last stage waits on a full queue
	assign adv      = !v_s3 || !q_full;
	assign in_ready = adv;
	assign op_push  = v_s3 && !q_full;
	assign op       = op_s3;

	// stage 1: smallest fitting class for allocate, owning pool for free
	always_comb begin
		cls_a = CLS_W'(NUM_CLASSES - 1);
		for (int g = NUM_CLASSES - 1; g >= 0; g--) begin
			if (in_size <= ob_tab[g]) begin
				cls_a = CLS_W'(g);
			end
		end
		fit    = (in_size <= ob_tab[NUM_CLASSES-1]);
		addr_x = RNG_W'(in_addr);
		cls_f  = '0;
		for (int k = 1; k < CLS_SLOTS; k++) begin
			if (addr_x >= pbase_tab[k]) begin
				cls_f = CLS_W'(k);
			end
		end
		own   = (addr_x < OWN_LIM);
		off_f = ADDR_W'(addr_x - pbase_tab[cls_f]);
	end

	// stage 2: offset times reciprocal of the object size gives the index
	always_comb begin
		prod = PROD_W'(off_s1) * PROD_W'(rec_tab[cls_s1]);
		q_d  = FQ_W'(prod >> sh_tab[cls_s1]);
	end

	// stage 3: alignment and pool tail checks, build the queued request
	always_comb begin
		chk     = CHK_W'(q_s2) * CHK_W'(ob_tab[cls_s2]);
		aligned = (chk == CHK_W'(off_s2));
		in_pool = (ADDR_W'(q_s2) < ADDR_W'(cnt_tab[cls_s2]));
		op_d        = '0;
		op_d.cls    = cls_s2;
		op_d.status = ST_OK;
		if (act_s2 == ACT_FREE) begin
			if (bad_s2 || !aligned || !in_pool) begin
				op_d.kind   = OP_REJECT;
				op_d.status = ST_NOT_OWNED;
			end else begin
				op_d.kind = OP_FREE;
				op_d.idx  = IDX_MAX_W'(q_s2);
			end
		end else begin
			if (bad_s2) begin
				op_d.kind   = OP_REJECT;
				op_d.status = ST_TOO_LARGE;
			end else begin
				op_d.kind = OP_ALLOC;
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= in_action;
			cls_s1 <= (in_action == ACT_FREE) ? cls_f : cls_a;
			off_s1 <= off_f;
			bad_s1 <= (in_action == ACT_FREE) ? !own : !fit;
			act_s2 <= act_s1;
			cls_s2 <= cls_s1;
			off_s2 <= off_s1;
			bad_s2 <= bad_s1;
			q_s2   <= q_d;
			op_s3  <= op_d;
		end
	end

endmodule

@@ rtl/scsa_back.sv @@
// scsa_back: sequencer that pops or pushes the class free lists and forms results
// depends on scsa_pkg and scsa_ram; takes op_t requests from scsa_fifo
module scsa_back
	import scsa_pkg::*;
#(
	parameter int POOL_BYTES       = 1048576,
	parameter int MIN_OBJECT_BYTES = 32,
	parameter int NUM_CLASSES      = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  op_t               op,
	output logic              op_pop,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [ADDR_W-1:0] res_addr,
	output status_t           res_status
);

	localparam int unsigned COUNT0 = POOL_BYTES / MIN_OBJECT_BYTES;
	localparam int CNT_W  = $clog2(COUNT0 + 1);
	localparam int IDX_W  = $clog2(COUNT0);
	localparam int unsigned TOTAL = stack_total(COUNT0, NUM_CLASSES);
	localparam int SLOT_W = $clog2(TOTAL);
	localparam int SUM_W  = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;
	localparam int MUL_W  = IDX_W + OB_W;

	// per class constant tables
	logic [OB_W-1:0]   ob_tab    [CLS_SLOTS];
	logic [CNT_W-1:0]  cnt_tab   [CLS_SLOTS];
	logic [SLOT_W-1:0] sbase_tab [CLS_SLOTS];
	logic [ADDR_W-1:0] pbase_tab [CLS_SLOTS];

	for (genvar g = 0; g < CLS_SLOTS; g++) begin : g_tab
		localparam longint OB  = longint'(MIN_OBJECT_BYTES) << g;
		localparam longint CNT = (g < NUM_CLASSES) ? (longint'(COUNT0) >> g) : 0;
		localparam longint SB  = (g < NUM_CLASSES) ? longint'(stack_base(COUNT0, g)) : 0;
		localparam longint PB  = longint'(g) * longint'(POOL_BYTES);
		assign ob_tab[g]    = OB_W'(OB);
		assign cnt_tab[g]   = CNT_W'(CNT);
		assign sbase_tab[g] = SLOT_W'(SB);
		assign pbase_tab[g] = ADDR_W'(PB);
	end

	bk_state_t         state_q, state_d;
	logic [CNT_W-1:0]  fresh_q [NUM_CLASSES];
	logic [CNT_W-1:0]  depth_q [NUM_CLASSES];
	logic [CNT_W-1:0]  fresh_sel, depth_sel;
	logic              ovf;
	status_t           status_d;

	logic              do_push, do_spop, do_fresh, res_load;
	logic [SLOT_W-1:0] slot_w, slot_r;
	logic [IDX_W-1:0]  ram_rdata;

	logic [CLS_W-1:0]  cls_q;
	status_t           status_q;
	logic              has_addr_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] prod_q;
	logic              res_valid_q;
	logic [ADDR_W-1:0] res_addr_q;
	status_t           res_status_q;

	// counters of the class at the queue head
	always_comb begin
		fresh_sel = '0;
		depth_sel = '0;
		for (int g = 0; g < NUM_CLASSES; g++) begin
			if (op.cls == CLS_W'(g)) begin
				fresh_sel = fresh_q[g];
				depth_sel = depth_q[g];
			end
		end
		ovf    = ({1'b0, fresh_sel} + {1'b0, depth_sel}) >= {1'b0, cnt_tab[op.cls]};
		slot_w = SLOT_W'(SUM_W'(sbase_tab[op.cls]) + SUM_W'(depth_sel));
		slot_r = SLOT_W'(SUM_W'(sbase_tab[op.cls]) + SUM_W'(depth_sel) - 1'b1);
	end

	// result code decided when the request is taken
	always_comb begin
		case (op.kind)
			OP_ALLOC: status_d = (depth_sel != '0 || fresh_sel != '0) ? ST_OK : ST_EMPTY;
			OP_FREE:  status_d = ovf ? ST_OVERFLOW : ST_OK;
			default:  status_d = op.status;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (op_valid) begin
					case (op.kind)
						OP_ALLOC: begin
							if (depth_sel != '0) begin
								state_d = BK_READ;
							end else if (fresh_sel != '0) begin
								state_d = BK_MUL;
							end else begin
								state_d = BK_DONE;
							end
						end
						default: state_d = BK_DONE;
					endcase
				end
			end
			BK_READ: state_d = BK_MUL;
			BK_MUL:  state_d = BK_DONE;
			BK_DONE: begin
				if (res_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		op_pop   = (state_q == BK_IDLE) && op_valid;
		do_push  = op_pop && (op.kind == OP_FREE) && !ovf;
		do_spop  = op_pop && (op.kind == OP_ALLOC) && (depth_sel != '0);
		do_fresh = op_pop && (op.kind == OP_ALLOC) && (depth_sel == '0) &&
			(fresh_sel != '0);
		res_load = (state_q == BK_DONE) && (!res_valid_q || res_ready);
	end

	// freed object stacks of all classes, packed one after another
	scsa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (TOTAL)
	) u_stack (
		.clk   (clk),
		.we    (do_push),
		.waddr (slot_w),
		.wdata (IDX_W'(op.idx)),
		.re    (do_spop),
		.raddr (slot_r),
		.rdata (ram_rdata)
	);

	// state register and per class counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			for (int g = 0; g < NUM_CLASSES; g++) begin
				fresh_q[g] <= CNT_W'(COUNT0 >> g);
				depth_q[g] <= '0;
			end
		end else begin
			state_q <= state_d;
			for (int g = 0; g < NUM_CLASSES; g++) begin
				if (op.cls == CLS_W'(g)) begin
					if (do_push) begin
						depth_q[g] <= depth_q[g] + 1'b1;
					end
					if (do_spop) begin
						depth_q[g] <= depth_q[g] - 1'b1;
					end
					if (do_fresh) begin
						fresh_q[g] <= fresh_q[g] - 1'b1;
					end
				end
			end
		end
	end

	// request datapath: index, then index times object size
	always_ff @(posedge clk) begin
		if (op_pop) begin
			cls_q      <= op.cls;
			status_q   <= status_d;
			has_addr_q <= (op.kind == OP_ALLOC) && (status_d == ST_OK);
			idx_q      <= IDX_W'(fresh_sel - 1'b1);
		end
		if (state_q == BK_READ) begin
			idx_q <= ram_rdata;
		end
		if (state_q == BK_MUL) begin
			prod_q <= ADDR_W'(MUL_W'(idx_q) * MUL_W'(ob_tab[cls_q]));
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload; address wraps to the 22 bit space
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_addr_q   <= has_addr_q ? (prod_q + pbase_tab[cls_q]) : '0;
			res_status_q <= status_q;
		end
	end

	assign res_valid  = res_valid_q;
	assign res_addr   = res_addr_q;
	assign res_status = res_status_q;

endmodule

@@ rtl/size_class_slab_allocator.sv @@
// size_class_slab_allocator: a request passes the front classifier and the queue. the back
// sequencer takes a free or rejected request straight to its result, an allocate from fresh
// objects via the index to address multiply, from freed objects via the stack ram registered
// read and the multiply, one request at a time. front pipeline and queue run ahead.
// arst_n clears all control state; fresh counts load each class's object count, stack
// memory is not cleared and needs no clearing pass since only pushed entries are read.
module size_class_slab_allocator
	import scsa_pkg::*;
#(
	parameter int POOL_BYTES       = 1048576,
	parameter int MIN_OBJECT_BYTES = 32,
	parameter int NUM_CLASSES      = 4,
	parameter int QUEUE_DEPTH      = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// request_size [15:0], free_address [37:16], zero [39:38]
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// action [0]
	input  logic [S_USER_W-1:0] s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// object_address [21:0], status [24:22], zero [31:25]
	output logic [M_DATA_W-1:0] m_axis_tdata
);

	op_t               fr_op, q_op;
	logic              fr_push, q_full, q_empty, q_pop;
	logic [ADDR_W-1:0] res_addr;
	status_t           res_status;

	// classify requests
	scsa_front #(
		.POOL_BYTES       (POOL_BYTES),
		.MIN_OBJECT_BYTES (MIN_OBJECT_BYTES),
		.NUM_CLASSES      (NUM_CLASSES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser[0]),
		.in_size   (s_axis_tdata[SIZE_W-1:0]),
		.in_addr   (s_axis_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
		.op_push   (fr_push),
		.op        (fr_op),
		.q_full    (q_full)
	);

	// decouple front and back
	scsa_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.wdata  (fr_op),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_op),
		.empty  (q_empty)
	);

	// carry out pops and pushes of the free lists
	scsa_back #(
		.POOL_BYTES       (POOL_BYTES),
		.MIN_OBJECT_BYTES (MIN_OBJECT_BYTES),
		.NUM_CLASSES      (NUM_CLASSES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (!q_empty),
		.op         (q_op),
		.op_pop     (q_pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_addr   (res_addr),
		.res_status (res_status)
	);

	// result packing
	assign m_axis_tdata = {{(M_DATA_W - ADDR_W - STATUS_W){1'b0}}, res_status, res_addr};

endmodule

@@ rtl/scsa_checker.sv @@
// scsa_checker: port level checks on the result stream of the slab allocator
// depends on scsa_pkg; bound to size_class_slab_allocator at the end of this file
module scsa_checker
	import scsa_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [M_DATA_W-1:0] m_axis_tdata
);

	logic [ADDR_W-1:0]   res_addr;
	logic [STATUS_W-1:0] res_status;

	assign res_addr   = m_axis_tdata[ADDR_W-1:0];
	assign res_status = m_axis_tdata[ADDR_W+STATUS_W-1:ADDR_W];

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// every failure reports a zero address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res_status != ST_OK) |-> (res_addr == '0))
		else $error("failed request carries an address");

	// status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res_status == ST_OK || res_status == ST_EMPTY ||
			res_status == ST_TOO_LARGE || res_status == ST_NOT_OWNED ||
			res_status == ST_OVERFLOW))
		else $error("undefined status code");

	// padding bits of the result stay clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[M_DATA_W-1:ADDR_W+STATUS_W] == '0))
		else $error("result padding not zero");

endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
